// ===== src/tsas_pkg.sv =====
// Package for the Thompson-sampling arm selector: shared constants, types and state codes.
// No dependencies; used by tsas_draw, tsas_div and the top level.
package tsas_pkg;

    localparam int MAX_ARMS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int REG_NUM_ARMS = 0;
    localparam int REG_RNG_SEED = 1;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 31;

    localparam logic [30:0] LCG_MUL = 31'd1103515245;
    localparam logic [30:0] LCG_ADD = 31'd12345;
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    // Gamma sums carry 24 fraction bits. A draw stays below 2^29 and a sum holds at most
    // 2^24 draws for the widest counters, so 54 bits never overflow.
    localparam int SUM_BITS = 54;
    localparam int DEN_BITS = 55;   // sum of two gamma values

    typedef enum logic [0:0] {
        ACT_SAMPLE = 1'b0,
        ACT_UPDATE = 1'b1
    } t_action;

    // Draw unit states, one-hot.
    typedef enum logic [6:0] {
        D_IDLE  = 7'b0000001,
        D_LCG   = 7'b0000010,
        D_NORM  = 7'b0000100,
        D_SQR   = 7'b0001000,
        D_MUL   = 7'b0010000,
        D_SHIFT = 7'b0100000,
        D_DONE  = 7'b1000000
    } t_draw_state;

    // Top-level sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD  = 10'b0000000010,
        S_GA    = 10'b0000000100,
        S_GB    = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_CMP   = 10'b0000100000,
        S_OUT   = 10'b0001000000,
        S_READ  = 10'b0010000000,
        S_WRITE = 10'b0100000000,
        S_CLR   = 10'b1000000000
    } t_seq_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_draw_ctl;

endpackage

// ===== src/tsas_draw.sv =====
// One exponential variate per request: LCG step, log2 by repeated squaring, scale by ln 2.
// Depends on tsas_pkg. A single 31x31 / 32x32 multiplier is reused by every step.
module tsas_draw (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_seed_load,
    input  logic [30:0]           i_seed,
    input  logic                  i_start,
    output tsas_pkg::t_draw_ctl   o_ctl,
    output logic [31:0]           o_exp
);

    tsas_pkg::t_draw_state r_state, n_state;
    logic [30:0] r_rng;
    logic [39:0] r_v;
    logic [5:0]  r_pos;
    logic [31:0] r_m;        // Q2.30 mantissa; its square stays below 4.0 before halving
    logic [23:0] r_frac;
    logic [4:0]  r_cnt;
    logic [31:0] r_exp;
    logic [63:0] r_prod;

    // Shared multiplier operands.
    logic [31:0] w_a, w_b;
    logic [63:0] w_p;
    logic [31:0] w_d;
    logic [5:0]  w_lead;
    logic [63:0] w_sq;

    assign w_d = 32'(40 << 24) - {2'b0, r_pos, r_frac};
    always_comb begin
        unique case (r_state)
            tsas_pkg::D_MUL: begin
                w_a = w_d;
                w_b = tsas_pkg::LN2_Q32;
            end
            tsas_pkg::D_SQR: begin
                w_a = r_m;
                w_b = r_m;
            end
            default: begin
                w_a = {1'b0, r_rng};
                w_b = {1'b0, tsas_pkg::LCG_MUL};
            end
        endcase
    end
    assign w_p  = w_a * w_b;
    assign w_sq = w_p >> 30;

    always_comb begin
        w_lead = '0;
        for (int i = 0; i < 40; i++) begin
            if (r_v[i]) w_lead = 6'(i);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsas_pkg::D_IDLE:  if (i_start) n_state = tsas_pkg::D_LCG;
            tsas_pkg::D_LCG:   n_state = tsas_pkg::D_NORM;
            tsas_pkg::D_NORM:  n_state = tsas_pkg::D_SQR;
            tsas_pkg::D_SQR:   if (r_cnt == 5'd23) n_state = tsas_pkg::D_MUL;
            tsas_pkg::D_MUL:   n_state = tsas_pkg::D_SHIFT;
            tsas_pkg::D_SHIFT: n_state = tsas_pkg::D_DONE;
            tsas_pkg::D_DONE:  n_state = tsas_pkg::D_IDLE;
            default:           n_state = tsas_pkg::D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsas_pkg::D_IDLE;
            r_rng   <= 31'd1;
        end else begin
            r_state <= n_state;
            if (i_seed_load) begin
                r_rng <= i_seed;
            end else if (r_state == tsas_pkg::D_LCG) begin
                r_rng <= w_p[30:0] + tsas_pkg::LCG_ADD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tsas_pkg::D_LCG: begin
                r_v <= {w_p[30:0] + tsas_pkg::LCG_ADD, 9'd0} + 40'd1;
            end
            tsas_pkg::D_NORM: begin
                r_pos  <= w_lead;
                r_frac <= '0;
                r_cnt  <= '0;
                if (w_lead >= 6'd30) r_m <= 32'(r_v >> (w_lead - 6'd30));
                else r_m <= 32'(r_v << (6'd30 - w_lead));
            end
            tsas_pkg::D_SQR: begin
                r_cnt <= r_cnt + 5'd1;
                if (w_sq[31]) begin
                    r_frac <= {r_frac[22:0], 1'b1};
                    r_m    <= 32'(w_sq >> 1);
                end else begin
                    r_frac <= {r_frac[22:0], 1'b0};
                    r_m    <= w_sq[31:0];
                end
            end
            tsas_pkg::D_MUL:   r_prod <= w_p + 64'h8000_0000;
            tsas_pkg::D_SHIFT: r_exp <= r_prod[63:32];
            default: ;
        endcase
    end

    assign o_ctl.start = (r_state == tsas_pkg::D_IDLE) && i_start;
    assign o_ctl.done  = (r_state == tsas_pkg::D_DONE);
    assign o_exp       = r_exp;

endmodule

// ===== src/tsas_div.sv =====
// Restoring divider, one quotient bit a cycle: floor(a * 2^32 / den).
// Depends on tsas_pkg for the operand widths.
module tsas_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [tsas_pkg::SUM_BITS-1:0]   i_num,
    input  logic [tsas_pkg::DEN_BITS-1:0]   i_den,
    output logic                            o_done,
    output logic [31:0]                     o_quo
);

    logic                          r_busy;
    logic [5:0]                    r_cnt;
    logic [tsas_pkg::DEN_BITS:0]   r_rem;
    logic [tsas_pkg::DEN_BITS-1:0] r_den;
    logic [31:0]                   r_quo;
    logic                          r_done;
    logic [tsas_pkg::DEN_BITS:0]   w_sh;

    assign w_sh = {r_rem[tsas_pkg::DEN_BITS-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= (tsas_pkg::DEN_BITS+1)'(i_num);
                r_den  <= i_den;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== src/thompson_sampling_arm_selector_unit.sv =====
// Top level of the Thompson-sampling arm selector: counters, sequencer, handshakes.
// Depends on tsas_pkg, tsas_draw and tsas_div.
//
//  Channel   Direction  Payload (low bit first)
//  s_axis    in         tdata: action[0], arm[4:1], reward[5], zero pad [7:6]
//  m_axis    out        tdata: chosen_arm[3:0], status[4], zero pad [7:5]
//  cfg       in         i_cfg_we, i_cfg_idx (0 num_arms, 1 rng_seed), i_cfg_data
//
// Reset is synchronous and active low; it loads the seed 1 and starts a clearing pass that
// zeroes one arm's counters a cycle, over all MAX_ARMS arms, with s_axis_tready low.
// A valid update reads, then writes back its counters in S_READ and S_WRITE before its result
// becomes valid; for an inactive arm the result becomes valid at the accepting edge itself.
// A sample visits each active arm in turn and sums pulls + 2 exponential draws, each one
// running the 24-step squaring loop in the shared multiplier; it then runs the 32-step
// division and the sequencing, and finally loads the result into the output register.
// The block takes one transaction at a time; s_axis_tready stays low until the result
// held in the output register has been taken.
module thompson_sampling_arm_selector_unit #(
    parameter int MAX_ARMS   = tsas_pkg::MAX_ARMS_DEF,
    parameter int COUNT_BITS = tsas_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // action, arm[3:0], reward
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // chosen_arm[3:0], status
    input  logic                              i_cfg_we,
    input  logic [tsas_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [tsas_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_ARMS);
    localparam int NW = $clog2(MAX_ARMS + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Counter stores, read into registers at one sequencer-chosen address at a time.
    logic [COUNT_BITS-1:0] r_pulls [MAX_ARMS];
    logic [COUNT_BITS-1:0] r_succ  [MAX_ARMS];

    tsas_pkg::t_seq_state r_state;
    logic [4:0]            r_num_arms;
    logic [NW-1:0]         w_active;
    logic [AW-1:0]         r_arm;       // arm being visited, updated or cleared
    logic                  r_reward;
    logic [COUNT_BITS-1:0] r_rd_p, r_rd_s;
    logic [COUNT_BITS:0]   r_left;      // draws still to sum
    logic [tsas_pkg::SUM_BITS-1:0] r_acc, r_ga;
    logic                  r_draw_busy;
    logic [31:0]           r_best;
    logic [AW-1:0]         r_best_arm;
    logic                  r_have;
    logic                  r_out_valid;
    logic [3:0]            r_out_arm;
    logic                  r_out_status;

    logic                  w_in_acc;
    logic [3:0]            w_in_arm;
    tsas_pkg::t_draw_ctl   w_dctl;
    logic [31:0]           w_exp;
    logic                  w_div_done;
    logic [31:0]           w_quo;
    logic                  w_seed_load;
    logic                  w_draw_go;
    logic [tsas_pkg::SUM_BITS-1:0] w_acc_new;
    logic [tsas_pkg::SUM_BITS-1:0] w_fix;

    always_comb begin
        if (r_num_arms == 5'd0) w_active = NW'(1);
        else if (32'(r_num_arms) > MAX_ARMS) w_active = NW'(MAX_ARMS);
        else w_active = NW'(r_num_arms);
    end

    assign w_in_arm      = s_axis_tdata[4:1];
    assign s_axis_tready = (r_state == tsas_pkg::S_IDLE) && !r_out_valid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_seed_load   = i_cfg_we
                           && (i_cfg_idx == tsas_pkg::CFG_IDX_BITS'(tsas_pkg::REG_RNG_SEED));
    assign w_draw_go     = ((r_state == tsas_pkg::S_GA) || (r_state == tsas_pkg::S_GB))
                           && !r_draw_busy && (r_left != '0);
    assign w_acc_new     = r_acc + tsas_pkg::SUM_BITS'(w_exp);
    assign w_fix         = (r_acc == '0) ? tsas_pkg::SUM_BITS'(1) : r_acc;

    tsas_draw u_draw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_load (w_seed_load),
        .i_seed      (i_cfg_data),
        .i_start     (w_draw_go),
        .o_ctl       (w_dctl),
        .o_exp       (w_exp)
    );

    tsas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == tsas_pkg::S_GB && r_left == '0 && !r_draw_busy),
        .i_num   (r_ga),
        .i_den   ({1'b0, r_ga} + {1'b0, w_fix}),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsas_pkg::S_CLR;
            r_arm       <= '0;
            r_num_arms  <= 5'd1;
            r_out_valid <= 1'b0;
            r_draw_busy <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == tsas_pkg::CFG_IDX_BITS'(tsas_pkg::REG_NUM_ARMS)) begin
                r_num_arms <= i_cfg_data[4:0];
            end
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            if (w_dctl.start) r_draw_busy <= 1'b1;
            if (w_dctl.done) begin
                r_draw_busy <= 1'b0;
                r_acc       <= w_acc_new;
                r_left      <= r_left - 1'b1;
            end
            unique case (r_state)
                tsas_pkg::S_CLR: begin
                    r_pulls[r_arm] <= '0;
                    r_succ[r_arm]  <= '0;
                    if (r_arm == AW'(MAX_ARMS - 1)) r_state <= tsas_pkg::S_IDLE;
                    else r_arm <= r_arm + 1'b1;
                end
                tsas_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_reward <= s_axis_tdata[5];
                        r_have   <= 1'b0;
                        if (s_axis_tdata[0] == tsas_pkg::ACT_UPDATE) begin
                            if (NW'(w_in_arm) >= w_active || 32'(w_in_arm) >= MAX_ARMS) begin
                                r_out_arm    <= '0;
                                r_out_status <= 1'b1;
                                r_out_valid  <= 1'b1;
                            end else begin
                                r_arm   <= AW'(w_in_arm);
                                r_state <= tsas_pkg::S_READ;
                            end
                        end else begin
                            r_arm   <= '0;
                            r_state <= tsas_pkg::S_LOAD;
                        end
                    end
                end
                tsas_pkg::S_READ: begin
                    r_rd_p  <= r_pulls[r_arm];
                    r_rd_s  <= r_succ[r_arm];
                    r_state <= tsas_pkg::S_WRITE;
                end
                tsas_pkg::S_WRITE: begin
                    if (r_rd_p != CNT_MAX) r_pulls[r_arm] <= r_rd_p + 1'b1;
                    if (r_reward && r_rd_s != CNT_MAX) begin
                        r_succ[r_arm] <= r_rd_s + 1'b1;
                    end
                    r_out_arm    <= '0;
                    r_out_status <= 1'b0;
                    r_out_valid  <= 1'b1;
                    r_state      <= tsas_pkg::S_IDLE;
                end
                tsas_pkg::S_LOAD: begin
                    r_rd_p  <= r_pulls[r_arm];
                    r_rd_s  <= r_succ[r_arm];
                    r_left  <= (COUNT_BITS+1)'(r_succ[r_arm]) + 1'b1;
                    r_acc   <= '0;
                    r_state <= tsas_pkg::S_GA;
                end
                tsas_pkg::S_GA: begin
                    if (r_left == '0 && !r_draw_busy) begin
                        r_ga <= w_fix;
                        r_acc <= '0;
                        r_left <= (r_rd_p >= r_rd_s)
                                  ? (COUNT_BITS+1)'(r_rd_p - r_rd_s) + 1'b1
                                  : (COUNT_BITS+1)'(1);
                        r_state <= tsas_pkg::S_GB;
                    end
                end
                tsas_pkg::S_GB: begin
                    if (r_left == '0 && !r_draw_busy) begin
                        r_state <= tsas_pkg::S_DIV;
                    end
                end
                tsas_pkg::S_DIV: begin
                    if (w_div_done) begin
                        if (!r_have || w_quo > r_best) begin
                            r_best     <= w_quo;
                            r_best_arm <= r_arm;
                            r_have     <= 1'b1;
                        end
                        r_state <= tsas_pkg::S_CMP;
                    end
                end
                tsas_pkg::S_CMP: begin
                    if (NW'(r_arm) + 1'b1 >= w_active) begin
                        r_state <= tsas_pkg::S_OUT;
                    end else begin
                        r_arm   <= r_arm + 1'b1;
                        r_state <= tsas_pkg::S_LOAD;
                    end
                end
                tsas_pkg::S_OUT: begin
                    r_out_arm    <= 4'(r_best_arm);
                    r_out_status <= 1'b0;
                    r_out_valid  <= 1'b1;
                    r_state      <= tsas_pkg::S_IDLE;
                end
                default: r_state <= tsas_pkg::S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_status, r_out_arm};

endmodule

// ===== src/tsas_checker.sv =====
// Port-level checker for the arm selector, bound to the top level.
// Depends on the top level's port list only.
module tsas_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while busy");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0)
        else $error("error result with nonzero arm");

endmodule

bind thompson_sampling_arm_selector_unit tsas_checker u_tsas_checker (.*);
